@@ src/gls_pkg.sv @@
// gls_pkg: shared types and constants for the gated line smoother
// holds beat structs, configuration indexes and the sequencer state type
// no dependencies
package gls_pkg;

	localparam int COORD_W = 14;
	localparam int XY_W    = 16;
	localparam int ICPT_W  = 20;
	localparam int CFG_W   = 15;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_GATE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_KEEP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT_KEEP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd3;

	typedef struct packed {
		logic               restart;
		logic [COORD_W-1:0] seg_start_x;
		logic [COORD_W-1:0] seg_start_y;
		logic [COORD_W-1:0] seg_end_x;
		logic [COORD_W-1:0] seg_end_y;
	} seg_t;

	typedef struct packed {
		logic signed [XY_W-1:0]   line_start_x;
		logic signed [XY_W-1:0]   line_end_x;
		logic signed [XY_W-1:0]   line_end_y;
		logic signed [XY_W-1:0]   smoothed_slope;
		logic signed [ICPT_W-1:0] smoothed_intercept;
		logic                     tracked;
		logic                     div_fault;
	} line_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M_GO,
		ST_M_WAIT,
		ST_B_MUL,
		ST_B_SUM,
		ST_GATE,
		ST_BL_S,
		ST_BL_I,
		ST_A_GO,
		ST_A_WAIT,
		ST_E_MUL,
		ST_E_SUM,
		ST_S_GO,
		ST_S_WAIT,
		ST_DONE
	} state_t;

endpackage

@@ src/gls_div.sv @@
// gls_div: bit-serial restoring divider, one quotient bit per cycle
// sign-magnitude operands, quotient truncated toward zero, saturated to 16 bits
// depends on gls_pkg
module gls_div import gls_pkg::*; #(
	parameter int NUM_W = 28
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   num_neg,
	input  logic [NUM_W-1:0]       num_mag,
	input  logic                   den_neg,
	input  logic [XY_W-1:0]        den_mag,
	output logic                   done,
	output logic signed [XY_W-1:0] quo,
	output logic                   fault
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [XY_W-1:0]  rem_q;
	logic [NUM_W-1:0] nq_q;
	logic [XY_W-1:0]  den_q;
	logic             neg_q;
	logic             zero_q;
	logic             numneg_q;

	logic [XY_W:0] rem_sh;
	logic [XY_W:0] rem_nx;
	logic          ge;

	always_comb begin
		rem_sh = {rem_q, nq_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NUM_W);
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= '0;
			nq_q     <= num_mag;
			den_q    <= den_mag;
			neg_q    <= num_neg ^ den_neg;
			zero_q   <= den_mag == '0;
			numneg_q <= num_neg;
		end else if (run_q) begin
			rem_q <= rem_nx[XY_W-1:0];
			nq_q  <= {nq_q[NUM_W-2:0], ge};
		end
	end

	always_comb begin
		fault = 1'b0;
		if (zero_q) begin
			fault = 1'b1;
			quo   = numneg_q ? 16'sh8000 : 16'sh7fff;
		end else if (neg_q) begin
			if (nq_q > NUM_W'(32768)) begin
				fault = 1'b1;
				quo   = 16'sh8000;
			end else begin
				quo = $signed(~nq_q[XY_W-1:0] + 16'd1);
			end
		end else begin
			if (nq_q > NUM_W'(32767)) begin
				fault = 1'b1;
				quo   = 16'sh7fff;
			end else begin
				quo = $signed(nq_q[XY_W-1:0]);
			end
		end
	end

	assign done = done_q;

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(run_q))
		else $error("divider done without a run");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> cnt_q == '0)
		else $error("divider count left over");
	a_no_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q)
		else $error("divider done while running");

endmodule

@@ src/gated_line_smoother.sv @@
// gated_line_smoother: top level, segment slope/intercept, gated smoothing, anchor
// sequencer around one shared bit-serial divider and combinational multiplies
// depends on gls_pkg and gls_div
//
//  channel | signals                                   | direction
//  seg     | seg_valid, seg_ready, seg (seg_t)         | in
//  line    | line_valid, line_ready, line (line_t)     | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// one segment at a time; each segment runs three divisions on the serial divider when blended
// or on restart, and two when the gate fails
// a new segment is taken while the previous result waits in the output register
// a stalled output holds the finished result until line_ready
// reset is asynchronous; configuration is always accepted
module gated_line_smoother import gls_pkg::*; #(
	parameter int SLOPE_FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 seg_valid,
	output logic                 seg_ready,
	input  seg_t                 seg,
	output logic                 line_valid,
	input  logic                 line_ready,
	output line_t                line,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int F     = SLOPE_FRAC_BITS;
	localparam int NUM_W = 20 + F;
	localparam logic signed [31:0] HALF = 32'sd1 <<< (F - 1);

	state_t state_q, state_d;

	logic [14:0] gate_q;
	logic [8:0]  skeep_q, ikeep_q;
	logic [10:0] height_q;

	logic signed [XY_W-1:0]   slope_q, anchor_x_q, m_q, endy_q, startx_q;
	logic signed [ICPT_W-1:0] icpt_q, b_q;
	logic [10:0]              row_q;
	seg_t                     seg_q;
	logic signed [31:0]       prod_q;
	logic                     tracked_q, fault_q;
	line_t                    line_q;
	logic                     line_valid_q;

	logic                   div_start, div_done, div_fault;
	logic                   div_num_neg, div_den_neg;
	logic [NUM_W-1:0]       div_num_mag;
	logic [XY_W-1:0]        div_den_mag;
	logic signed [XY_W-1:0] div_quo;

	logic signed [20:0] nv;
	logic [19:0]        nmag;
	logic signed [XY_W-1:0] dv;
	logic out_load;

	assign cfg_ready  = 1'b1;
	assign seg_ready  = state_q == ST_IDLE;
	assign line_valid = line_valid_q;
	assign line       = line_q;
	assign out_load   = state_q == ST_DONE && (!line_valid_q || line_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q   <= 15'd77;
			skeep_q  <= 9'd166;
			ikeep_q  <= 9'd166;
			height_q <= 11'd128;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SLOPE_GATE:     gate_q   <= cfg_data;
				CFG_SLOPE_KEEP:     skeep_q  <= cfg_data[8:0];
				CFG_INTERCEPT_KEEP: ikeep_q  <= cfg_data[8:0];
				CFG_IMAGE_HEIGHT:   height_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		nv = '0;
		dv = slope_q;
		unique case (state_q)
			ST_M_GO: begin
				div_start = 1'b1;
				nv = 21'(signed'({1'b0, seg_q.seg_end_y}))
					- 21'(signed'({1'b0, seg_q.seg_start_y}));
				dv = 16'(signed'({1'b0, seg_q.seg_end_x}))
					- 16'(signed'({1'b0, seg_q.seg_start_x}));
			end
			ST_A_GO: begin
				div_start = 1'b1;
				nv = $signed({6'b0, row_q, 4'b0}) - 21'(icpt_q);
			end
			ST_S_GO: begin
				div_start = 1'b1;
				nv = 21'sd0 - 21'(icpt_q);
			end
			default: ;
		endcase
		div_num_neg = nv[20];
		nmag        = nv[20] ? 20'(-nv) : nv[19:0];
		div_num_mag = NUM_W'(nmag) << F;
		div_den_neg = dv[XY_W-1];
		div_den_mag = dv[XY_W-1] ? 16'(-dv) : 16'(dv);
	end

	gls_div #(.NUM_W(NUM_W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_neg (div_num_neg),
		.num_mag (div_num_mag),
		.den_neg (div_den_neg),
		.den_mag (div_den_mag),
		.done    (div_done),
		.quo     (div_quo),
		.fault   (div_fault)
	);

	// datapath helpers
	logic signed [31:0] b_full, e_full, bl_s, bl_i;
	logic signed [16:0] mdiff;
	logic [16:0]        mabs;
	logic [8:0]         sk, ik;
	logic signed [16:0] sdel;
	logic signed [20:0] idel;

	always_comb begin
		b_full = 32'(signed'({1'b0, seg_q.seg_start_y})) - ((prod_q + HALF) >>> F);
		e_full = ((prod_q + HALF) >>> F) + 32'(icpt_q);
		mdiff  = 17'(m_q) - 17'(slope_q);
		mabs   = mdiff[16] ? 17'(-mdiff) : 17'(mdiff);
		sk     = skeep_q > 9'd256 ? 9'd256 : skeep_q;
		ik     = ikeep_q > 9'd256 ? 9'd256 : ikeep_q;
		sdel   = 17'(slope_q) - 17'(m_q);
		idel   = 21'(icpt_q) - 21'(b_q);
		bl_s   = ((32'(m_q) <<< 8) + 32'(signed'({1'b0, sk})) * 32'(sdel) + 32'sd128) >>> 8;
		bl_i   = ((32'(b_q) <<< 8) + 32'(signed'({1'b0, ik})) * 32'(idel) + 32'sd128) >>> 8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			line_valid_q <= 1'b0;
			slope_q      <= '0;
			icpt_q       <= '0;
			anchor_x_q   <= '0;
			row_q        <= 11'd225;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				line_valid_q <= 1'b1;
			end else if (line_ready) begin
				line_valid_q <= 1'b0;
			end
			if (state_q == ST_GATE && seg_q.restart) begin
				slope_q <= m_q;
				icpt_q  <= b_q;
				row_q   <= height_q;
			end
			if (state_q == ST_BL_S) begin
				slope_q <= bl_s[XY_W-1:0];
			end
			if (state_q == ST_BL_I) begin
				icpt_q <= bl_i[ICPT_W-1:0];
			end
			if (state_q == ST_A_WAIT && div_done) begin
				anchor_x_q <= div_quo;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (seg_valid) begin
					seg_q     <= seg;
					fault_q   <= 1'b0;
					tracked_q <= 1'b0;
				end
			end
			ST_M_WAIT: begin
				if (div_done) begin
					m_q     <= div_quo;
					fault_q <= fault_q | div_fault;
				end
			end
			ST_B_MUL: prod_q <= 32'(m_q) * 32'(signed'({1'b0, seg_q.seg_start_x}));
			ST_B_SUM: begin
				if (b_full > 32'sd524287) begin
					b_q <= 20'sh7ffff;
					fault_q <= 1'b1;
				end else if (b_full < -32'sd524288) begin
					b_q <= 20'sh80000;
					fault_q <= 1'b1;
				end else begin
					b_q <= b_full[ICPT_W-1:0];
				end
			end
			ST_GATE: begin
				if (!seg_q.restart && mabs < {2'b0, gate_q}) begin
					tracked_q <= 1'b1;
				end
			end
			ST_A_WAIT: begin
				if (div_done) begin
					fault_q <= fault_q | div_fault;
					endy_q  <= $signed({1'b0, row_q, 4'b0});
				end
			end
			ST_E_MUL: prod_q <= 32'(slope_q) * 32'(anchor_x_q);
			ST_E_SUM: begin
				if (e_full > 32'sd32767) begin
					endy_q  <= 16'sh7fff;
					fault_q <= 1'b1;
				end else if (e_full < -32'sd32768) begin
					endy_q  <= 16'sh8000;
					fault_q <= 1'b1;
				end else begin
					endy_q <= e_full[XY_W-1:0];
				end
			end
			ST_S_WAIT: begin
				if (div_done) begin
					startx_q <= div_quo;
					fault_q  <= fault_q | div_fault;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			line_q.line_start_x       <= startx_q;
			line_q.line_end_x         <= anchor_x_q;
			line_q.line_end_y         <= endy_q;
			line_q.smoothed_slope     <= slope_q;
			line_q.smoothed_intercept <= icpt_q;
			line_q.tracked            <= tracked_q;
			line_q.div_fault          <= fault_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (seg_valid) state_d = ST_M_GO;
			ST_M_GO:   state_d = ST_M_WAIT;
			ST_M_WAIT: if (div_done) state_d = ST_B_MUL;
			ST_B_MUL:  state_d = ST_B_SUM;
			ST_B_SUM:  state_d = ST_GATE;
			ST_GATE: begin
				if (seg_q.restart) begin
					state_d = ST_A_GO;
				end else if (mabs < {2'b0, gate_q}) begin
					state_d = ST_BL_S;
				end else begin
					state_d = ST_E_MUL;
				end
			end
			ST_BL_S:   state_d = ST_BL_I;
			ST_BL_I:   state_d = ST_A_GO;
			ST_A_GO:   state_d = ST_A_WAIT;
			ST_A_WAIT: if (div_done) state_d = seg_q.restart ? ST_S_GO : ST_E_MUL;
			ST_E_MUL:  state_d = ST_E_SUM;
			ST_E_SUM:  state_d = ST_S_GO;
			ST_S_GO:   state_d = ST_S_WAIT;
			ST_S_WAIT: if (div_done) state_d = ST_DONE;
			ST_DONE:   if (!line_valid_q || line_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_M_WAIT || state_q == ST_A_WAIT || state_q == ST_S_WAIT))
		else $error("divider result outside a wait state");
	a_restart_untracked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && seg_q.restart) |-> !tracked_q)
		else $error("restart marked as tracked");
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(line_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done");

endmodule

@@ verif/testbench.sv @@
// testbench for gated_line_smoother: directed table, register extremes, then random segments,
// each result beat checked against an in-bench line tracker model
// depends on gls_pkg and the gated_line_smoother rtl
module testbench;
	import gls_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 8;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic seg_valid = 1'b0;
	logic seg_ready;
	seg_t seg = '0;
	logic line_valid;
	logic line_ready = 1'b0;
	line_t line;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	gated_line_smoother #(.SLOPE_FRAC_BITS(FB)) u_top (
		.clk(clk), .arst_n(arst_n),
		.seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg),
		.line_valid(line_valid), .line_ready(line_ready), .line(line),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// tracker state and settings
	longint gate_q, skeep_q, ikeep_q, height_q;
	longint slope_q, icpt_q, ax_q, arow_q;

	line_t pending_lines[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	function automatic longint floor_shr(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -(((-v) - 1) >>> s) - 1;
	endfunction

	function automatic longint round_shr(longint v, int s);
		return floor_shr(v + (longint'(1) << (s - 1)), s);
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi, ref bit flt);
		if (v > hi) begin
			flt = 1'b1;
			return hi;
		end
		if (v < lo) begin
			flt = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic longint sat_quot(longint num, longint den, ref bit flt);
		if (den == 0) begin
			flt = 1'b1;
			return (num >= 0) ? 32767 : -32768;
		end
		return sat(num / den, -32768, 32767, flt);
	endfunction

	function automatic longint mix(longint old, longint nw, longint keep);
		longint k;
		k = (keep > 256) ? 256 : keep;
		return floor_shr(k * old + (256 - k) * nw + 128, 8);
	endfunction

	function automatic line_t track_segment(seg_t s);
		line_t r;
		bit flt, trk;
		longint m, b, row_y, end_y, start_x, diff;
		flt = 1'b0;
		trk = 1'b0;
		m = sat_quot((longint'(s.seg_end_y) - longint'(s.seg_start_y)) * 256,
			longint'(s.seg_end_x) - longint'(s.seg_start_x), flt);
		b = sat(longint'(s.seg_start_y) - round_shr(m * longint'(s.seg_start_x), FB),
			-524288, 524287, flt);
		if (s.restart) begin
			slope_q = m;
			icpt_q = b;
			arow_q = height_q;
			row_y = arow_q * 16;
			ax_q = sat_quot((row_y - icpt_q) * 256, slope_q, flt);
			end_y = sat(row_y, -32768, 32767, flt);
		end else begin
			diff = m - slope_q;
			if (diff < 0)
				diff = -diff;
			if (diff < gate_q) begin
				trk = 1'b1;
				slope_q = mix(slope_q, m, skeep_q);
				icpt_q = mix(icpt_q, b, ikeep_q);
				row_y = arow_q * 16;
				ax_q = sat_quot((row_y - icpt_q) * 256, slope_q, flt);
			end
			end_y = sat(round_shr(slope_q * ax_q, FB) + icpt_q, -32768, 32767, flt);
		end
		start_x = sat_quot((0 - icpt_q) * 256, slope_q, flt);
		r.line_start_x = start_x[15:0];
		r.line_end_x = ax_q[15:0];
		r.line_end_y = end_y[15:0];
		r.smoothed_slope = slope_q[15:0];
		r.smoothed_intercept = icpt_q[19:0];
		r.tracked = trk;
		r.div_fault = flt;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// result beats checked at the rising edge
	always @(posedge clk) begin
		line_t e;
		if (arst_n && line_valid && line_ready) begin
			if (pending_lines.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				e = pending_lines.pop_front();
				if (line.line_start_x !== e.line_start_x)
					report_mismatch("line_start_x", line.line_start_x, e.line_start_x);
				if (line.line_end_x !== e.line_end_x)
					report_mismatch("line_end_x", line.line_end_x, e.line_end_x);
				if (line.line_end_y !== e.line_end_y)
					report_mismatch("line_end_y", line.line_end_y, e.line_end_y);
				if (line.smoothed_slope !== e.smoothed_slope)
					report_mismatch("smoothed_slope", line.smoothed_slope, e.smoothed_slope);
				if (line.smoothed_intercept !== e.smoothed_intercept)
					report_mismatch("smoothed_intercept", line.smoothed_intercept,
						e.smoothed_intercept);
				if (line.tracked !== e.tracked)
					report_mismatch("tracked", line.tracked, e.tracked);
				if (line.div_fault !== e.div_fault)
					report_mismatch("div_fault", line.div_fault, e.div_fault);
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((seg_valid && seg_ready) || (line_valid && line_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		line_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SLOPE_GATE:     gate_q = val & 16'h7FFF;
			CFG_SLOPE_KEEP:     skeep_q = val & 16'h1FF;
			CFG_INTERCEPT_KEEP: ikeep_q = val & 16'h1FF;
			default:            height_q = val & 16'h7FF;
		endcase
	endtask

	task automatic drain();
		while (pending_lines.size() != 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	// gap cycles happen before raising valid, never while it is up
	task automatic send_segment(seg_t s, bit has_exp, line_t want);
		line_t p;
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		@(negedge clk);
		p = track_segment(s);
		if (has_exp && p !== want)
			report_mismatch("directed row", 1, 0);
		pending_lines.push_back(p);
		seg <= s;
		seg_valid <= 1'b1;
		@(posedge clk);
		while (!seg_ready)
			@(posedge clk);
		@(negedge clk);
		seg_valid <= 1'b0;
	endtask

	function automatic seg_t mk(bit rs, int sx, int sy, int ex, int ey);
		seg_t s;
		s.restart = rs;
		s.seg_start_x = sx[13:0];
		s.seg_start_y = sy[13:0];
		s.seg_end_x = ex[13:0];
		s.seg_end_y = ey[13:0];
		return s;
	endfunction

	function automatic seg_t rand_seg(bit rs);
		int sx, sy, ex, ey;
		sx = $urandom_range(16383);
		sy = $urandom_range(16383);
		case ($urandom_range(4))
			0: begin
				ex = $urandom_range(16383);
				ey = $urandom_range(16383);
			end
			1: begin
				ex = sx;
				ey = $urandom_range(16383);
			end
			default: begin
				ex = sx + $urandom_range(400) - 200;
				ey = sy + $urandom_range(100) - 50;
				if (ex < 0) ex = 0;
				if (ex > 16383) ex = 16383;
				if (ey < 0) ey = 0;
				if (ey > 16383) ey = 16383;
			end
		endcase
		return mk(rs, sx, sy, ex, ey);
	endfunction

	// follow a line from frame to frame with small jitter and occasional random segments
	task automatic run_track(int count);
		seg_t s, base;
		base = rand_seg(1'b1);
		send_segment(base, 1'b0, '0);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0) begin
				s = rand_seg($urandom_range(3) == 0);
			end else begin
				s = base;
				s.restart = 1'b0;
				s.seg_start_x = base.seg_start_x ^ 14'($urandom_range(15));
				s.seg_end_y = base.seg_end_y ^ 14'($urandom_range(15));
			end
			send_segment(s, 1'b0, '0);
		end
	endtask

	typedef struct {
		seg_t s;
		bit has_exp;
		line_t want;
	} row_t;

	row_t rows[$];
	line_t w;

	initial begin
		gate_q = 77;
		skeep_q = 166;
		ikeep_q = 166;
		height_q = 128;
		slope_q = 0;
		icpt_q = 0;
		ax_q = 0;
		arow_q = 225;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// before any restart: zero slope gives zero divisor faults
		w = '0;
		w.line_start_x = 16'sd32767;
		w.line_end_y = 16'sd0;
		w.div_fault = 1'b1;
		rows.push_back('{mk(0, 0, 0, 0, 0), 1'b1, w});
		// horizontal restart: slope 0, b 0, anchor and start saturate
		w = '0;
		w.line_start_x = 16'sd32767;
		w.line_end_x = 16'sd32767;
		w.line_end_y = 16'sd2048;
		w.div_fault = 1'b1;
		rows.push_back('{mk(1, 0, 0, 16, 0), 1'b1, w});
		rows.push_back('{mk(1, 16383, 16383, 0, 0), 1'b0, '0});
		rows.push_back('{mk(0, 16383, 16383, 0, 0), 1'b0, '0});
		rows.push_back('{mk(0, 100, 200, 200, 300), 1'b0, '0});
		rows.push_back('{mk(1, 0, 16383, 1, 0), 1'b0, '0});
		rows.push_back('{mk(0, 0, 0, 1, 16383), 1'b0, '0});
		rows.push_back('{mk(1, 5, 0, 5, 16383), 1'b0, '0});
		rows.push_back('{mk(1, 5, 16383, 5, 0), 1'b0, '0});
		rows.push_back('{mk(1, 1000, 2000, 3000, 2500), 1'b0, '0});
		rows.push_back('{mk(0, 1000, 2000, 3000, 2510), 1'b0, '0});
		rows.push_back('{mk(0, 1000, 2000, 3000, 9000), 1'b0, '0});
		rows.push_back('{mk(0, 16383, 0, 0, 16383), 1'b0, '0});
		rows.push_back('{mk(1, 16383, 0, 0, 1), 1'b0, '0});
		foreach (rows[i])
			send_segment(rows[i].s, rows[i].has_exp, rows[i].want);
		drain();

		// extremes of every register
		write_reg(CFG_SLOPE_GATE, 0);
		write_reg(CFG_SLOPE_KEEP, 0);
		write_reg(CFG_INTERCEPT_KEEP, 256);
		write_reg(CFG_IMAGE_HEIGHT, 1024);
		send_segment(mk(1, 10, 20, 300, 900), 1'b0, '0);
		send_segment(mk(0, 10, 20, 300, 900), 1'b0, '0);
		drain();
		write_reg(CFG_SLOPE_GATE, 32767);
		write_reg(CFG_SLOPE_KEEP, 511);
		write_reg(CFG_INTERCEPT_KEEP, 0);
		write_reg(CFG_IMAGE_HEIGHT, 0);
		send_segment(mk(1, 10, 20, 300, 900), 1'b0, '0);
		send_segment(mk(0, 50, 8000, 16000, 20), 1'b0, '0);
		send_segment(mk(0, 16383, 16383, 16382, 0), 1'b0, '0);
		drain();
		write_reg(CFG_IMAGE_HEIGHT, 2047);
		write_reg(CFG_INTERCEPT_KEEP, 511);
		send_segment(mk(1, 0, 0, 16383, 16383), 1'b0, '0);
		drain();

		// random phases: receiver mostly idle, then sender mostly idle, then neither
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 60 : 0;
			recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 25 : 0;
			write_reg(CFG_SLOPE_GATE, (ph == 2) ? $urandom_range(32767) : $urandom_range(400));
			write_reg(CFG_SLOPE_KEEP, $urandom_range(256));
			write_reg(CFG_INTERCEPT_KEEP, $urandom_range(256));
			write_reg(CFG_IMAGE_HEIGHT, $urandom_range(1024, 1));
			for (int t = 0; t < 8; t++)
				run_track(20);
			for (int i = 0; i < 30; i++)
				send_segment(rand_seg($urandom_range(1)), 1'b0, '0);
			drain();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
